/* rtl/core/adsr_envelope_sequencer_defines.svh */
// assertion macros for the envelope sequencer
`ifndef ADSR_ENVELOPE_SEQUENCER_DEFINES_SVH
`define ADSR_ENVELOPE_SEQUENCER_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define ADSR_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define ADSR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/adsr_pkg.sv */
// shared types and constants of the envelope sequencer
package adsr_pkg;

   // item actions
   localparam logic [2:0] ACT_TICK    = 3'd0;
   localparam logic [2:0] ACT_LOAD    = 3'd1;
   localparam logic [2:0] ACT_START   = 3'd2;
   localparam logic [2:0] ACT_DECAY   = 3'd3;
   localparam logic [2:0] ACT_RELEASE = 3'd4;

   // envelope phases
   localparam logic [3:0] PH_OFF       = 4'd0;
   localparam logic [3:0] PH_INITIAL   = 4'd1;
   localparam logic [3:0] PH_LOOPSTART = 4'd2;
   localparam logic [3:0] PH_LOOP      = 4'd3;
   localparam logic [3:0] PH_FADE      = 4'd4;
   localparam logic [3:0] PH_HANG      = 4'd5;
   localparam logic [3:0] PH_DECAY     = 4'd6;
   localparam logic [3:0] PH_RELEASE   = 4'd7;
   localparam logic [3:0] PH_SUSTAIN   = 4'd8;

   // pending request bits
   localparam int PEND_DECAY   = 0;
   localparam int PEND_RELEASE = 1;
   localparam int PEND_HANG    = 2;

   // special step counts in a program entry
   localparam logic signed [15:0] STEPS_STOP    = 16'sd0;
   localparam logic signed [15:0] STEPS_HANG    = -16'sd1;
   localparam logic signed [15:0] STEPS_JUMP    = -16'sd2;
   localparam logic signed [15:0] STEPS_RESTART = -16'sd3;

   // register indexes
   localparam logic [1:0] CSR_INITIAL_LEVEL = 2'd0;
   localparam logic [1:0] CSR_SUSTAIN_LEVEL = 2'd1;
   localparam logic [1:0] CSR_FADE_OUT_RATE = 2'd2;

   // release ends below this level
   localparam int FADE_OFF_LEVEL = 100;
   // hold time is sustain level over sixteen
   localparam int SUSTAIN_SHIFT = 4;
   // quotient bits of the divider
   localparam int DIV_STEPS = 32;

   typedef struct packed {
      logic [2:0]         action;
      logic [4:0]         entry_index;
      logic signed [15:0] entry_steps;
      logic signed [15:0] entry_arg;
      logic               hang_flag;
   } req_payload_type;

   typedef struct packed {
      logic signed [15:0] volume;
      logic [3:0]         phase;
      logic               active;
   } rsp_payload_type;

   typedef struct packed {
      logic        start;
      logic [31:0] dividend;
      logic [15:0] divisor;
      logic        negate;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] quotient;
   } div_rsp_type;

endpackage

/* rtl/core/adsr_chan_if.sv */
// valid/ready channels for request and response items
interface adsr_req_if import adsr_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface adsr_rsp_if import adsr_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/adsr_envelope_sequencer.sv */
// envelope sequencer top level: program store, step sequencer and output register
// a load, start or request item goes straight to S_DONE, registered once the output is free
// a tick of an off note goes to S_DONE; a ramp start waits in S_DIV on the serial divider
// a jump passes S_READ, S_DECODE, S_DIV, S_APPLY; a ramp step already underway passes S_STEP
// one item at a time; a stalled result holds back the result of the next one
// reset clears state, phase, levels, counters and flags; the store and data registers are not cleared
`include "adsr_envelope_sequencer_defines.svh"

module adsr_envelope_sequencer import adsr_pkg::*; #(
   parameter int PROGRAM_DEPTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   adsr_req_if.sink    req_chan,
   adsr_rsp_if.source  rsp_chan
);

   localparam int POS_W = $clog2(PROGRAM_DEPTH);

   // jump target modulo the store depth: multiply by a rounded-up reciprocal
   localparam int          JUMP_SHIFT = 16 + $clog2(PROGRAM_DEPTH);
   localparam logic [16:0] JUMP_RECIP =
      17'(((64'd1 << JUMP_SHIFT) + 64'(PROGRAM_DEPTH) - 64'd1) / 64'(PROGRAM_DEPTH));

   // sequencer states
   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_TICK   = 8'b0000_0010,
      S_READ   = 8'b0000_0100,
      S_DECODE = 8'b0000_1000,
      S_DIV    = 8'b0001_0000,
      S_STEP   = 8'b0010_0000,
      S_APPLY  = 8'b0100_0000,
      S_DONE   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic signed [15:0] initial_level_ff, initial_level_in;
   logic [14:0]        sustain_level_ff, sustain_level_in;
   logic [14:0]        fade_out_rate_ff, fade_out_rate_in;

   // envelope state
   logic [15:0]      level_ff, level_in;
   logic [31:0]      fine_level_ff, fine_level_in;
   logic [31:0]      ramp_rate_ff, ramp_rate_in;
   logic [15:0]      steps_left_ff, steps_left_in;
   logic [POS_W-1:0] position_ff, position_in;
   logic [3:0]       phase_ff, phase_in;
   logic [2:0]       pending_ff, pending_in;
   logic             ramp_mode_ff, ramp_mode_in;

   // output register
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   // program store
   logic [31:0]      program_mem [PROGRAM_DEPTH];
   logic [31:0]      rd_data_ff;
   logic             mem_we;
   logic [POS_W-1:0] mem_waddr;
   logic [31:0]      mem_wdata;
   logic [8:0]       load_index;
   logic             load_in_range;

   // divider link
   div_req_type div_req;
   div_rsp_type div_rsp;

   // decode of the entry read back from the store
   logic signed [15:0] entry_steps;
   logic [15:0]        entry_arg;
   logic [15:0]        ramp_diff;
   logic [31:0]        ramp_num;
   logic [31:0]        ramp_num_mag;
   logic [15:0]        steps_mag;

   // jump target reduction, quotient registered between the two halves
   logic [32:0] jump_prod;
   logic [15:0] jump_quo;
   logic [15:0] jump_quo_ff, jump_quo_in;
   logic [15:0] jump_back;
   logic [15:0] jump_rem;

   // decay and release arithmetic
   localparam logic signed [17:0] FADE_FLOOR = -18'sd32768;
   logic signed [17:0] fade_diff;
   logic signed [17:0] fade_cur;
   logic               sustain_on;
   logic [15:0]        fade_level;
   logic [3:0]         fade_phase;
   logic [15:0]        fade_steps;

   // misc
   logic [15:0]      sustain_dec;
   logic [31:0]      fine_sum;
   logic [15:0]      steps_dec;
   logic [POS_W-1:0] pos_inc;
   logic             req_xfer;

   adsr_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // idle means no item is in flight; a waiting result does not block the request side
   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   // load address check against the store depth
   assign load_index    = 9'(req_chan.data.entry_index);
   assign load_in_range = load_index < 9'(PROGRAM_DEPTH);

   // entry fields: steps in the upper half, argument in the lower half
   assign entry_steps  = $signed(rd_data_ff[31:16]);
   assign entry_arg    = rd_data_ff[15:0];
   // (target - level) << 16 keeps only the low half of the difference
   assign ramp_diff    = entry_arg - level_ff;
   assign ramp_num     = {ramp_diff, 16'h0000};
   assign ramp_num_mag = ramp_num[31] ? (32'd0 - ramp_num) : ramp_num;
   assign steps_mag    = entry_steps[15] ? (16'd0 - rd_data_ff[31:16]) : rd_data_ff[31:16];

   // jump target taken as unsigned: quotient first, remainder on the next cycle
   assign jump_prod = {17'd0, entry_arg} * {16'd0, JUMP_RECIP};
   assign jump_quo  = 16'(jump_prod >> JUMP_SHIFT);
   assign jump_back = jump_quo_ff * 16'(PROGRAM_DEPTH);
   assign jump_rem  = entry_arg - jump_back;

   // fade step for decay and release, saturating at the most negative level
   always_comb begin
      fade_diff  = {{2{level_ff[15]}}, level_ff} - {3'b000, fade_out_rate_ff};
      fade_cur   = (fade_diff < FADE_FLOOR) ? FADE_FLOOR : fade_diff;
      sustain_on = (sustain_level_ff != '0) && (phase_ff == PH_DECAY);
      fade_level = fade_cur[15:0];
      fade_phase = phase_ff;
      fade_steps = steps_left_ff;
      if (sustain_on) begin
         // decay stops on the sustain floor and loads the hold counter
         if (fade_cur < $signed({3'b000, sustain_level_ff})) begin
            fade_level = {1'b0, sustain_level_ff};
            fade_steps = 16'(sustain_level_ff >> SUSTAIN_SHIFT);
            fade_phase = PH_SUSTAIN;
         end
      end else if (fade_cur < $signed(18'(FADE_OFF_LEVEL))) begin
         // release, or decay with no sustain level, runs out: note goes silent
         fade_level = '0;
         fade_phase = PH_OFF;
      end
   end

   assign sustain_dec = steps_left_ff - 1'b1;
   assign fine_sum    = fine_level_ff + ramp_rate_ff;
   assign steps_dec   = steps_left_ff - 1'b1;
   assign pos_inc     = (position_ff == POS_W'(PROGRAM_DEPTH - 1)) ? '0 : position_ff + 1'b1;

   // configuration writes
   always_comb begin
      initial_level_in = initial_level_ff;
      sustain_level_in = sustain_level_ff;
      fade_out_rate_in = fade_out_rate_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_INITIAL_LEVEL: initial_level_in = $signed(csr_wdata);
            CSR_SUSTAIN_LEVEL: sustain_level_in = csr_wdata[14:0];
            CSR_FADE_OUT_RATE: fade_out_rate_in = csr_wdata[14:0];
            default: begin
            end
         endcase
      end
   end

   // step sequencer
   always_comb begin
      state_in      = state_ff;
      level_in      = level_ff;
      fine_level_in = fine_level_ff;
      ramp_rate_in  = ramp_rate_ff;
      steps_left_in = steps_left_ff;
      position_in   = position_ff;
      phase_in      = phase_ff;
      pending_in    = pending_ff;
      ramp_mode_in  = ramp_mode_ff;
      jump_quo_in   = jump_quo_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in   = rsp_data_ff;
      mem_we        = 1'b0;
      mem_waddr     = load_index[POS_W-1:0];
      mem_wdata     = {req_chan.data.entry_steps, req_chan.data.entry_arg};
      div_req       = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               state_in = S_DONE;
               case (req_chan.data.action)
                  ACT_TICK: state_in = S_TICK;
                  ACT_LOAD: mem_we = load_in_range;
                  ACT_START: begin
                     // a start drops waiting decay and release and takes the hang request from the item
                     phase_in   = PH_INITIAL;
                     pending_in = '0;
                     pending_in[PEND_HANG] = req_chan.data.hang_flag;
                  end
                  ACT_DECAY: pending_in[PEND_DECAY] = 1'b1;
                  ACT_RELEASE: pending_in[PEND_RELEASE] = 1'b1;
                  default: begin
                  end
               endcase
            end
         end

         S_TICK: begin
            state_in = S_APPLY;
            case (phase_ff)
               // an off note ignores the tick and keeps its requests waiting
               PH_OFF: state_in = S_DONE;
               PH_INITIAL: begin
                  level_in = initial_level_ff;
                  if (pending_ff[PEND_HANG]) begin
                     phase_in = PH_HANG;
                  end else begin
                     position_in   = '0;
                     fine_level_in = {initial_level_ff, 16'h0000};
                     phase_in      = PH_LOOP;
                     state_in      = S_READ;
                  end
               end
               PH_LOOPSTART: begin
                  position_in   = '0;
                  fine_level_in = {level_ff, 16'h0000};
                  phase_in      = PH_LOOP;
                  state_in      = S_READ;
               end
               PH_LOOP: state_in = S_READ;
               PH_FADE: state_in = S_STEP;
               PH_DECAY, PH_RELEASE: begin
                  level_in      = fade_level;
                  phase_in      = fade_phase;
                  steps_left_in = fade_steps;
               end
               PH_SUSTAIN: begin
                  steps_left_in = sustain_dec;
                  if (sustain_dec == '0) begin
                     phase_in = PH_RELEASE;
                  end
               end
               default: begin
               end
            endcase
         end

         // store output is registered: the entry at position shows up next cycle
         S_READ: state_in = S_DECODE;

         S_DECODE: begin
            steps_left_in = rd_data_ff[31:16];
            state_in      = S_APPLY;
            if (entry_steps == STEPS_STOP) begin
               phase_in = PH_OFF;
            end else if (entry_steps == STEPS_HANG) begin
               phase_in = PH_HANG;
            end else if (entry_steps == STEPS_JUMP) begin
               // jump target reduced modulo the store depth in S_DECODE and S_DIV
               jump_quo_in  = jump_quo;
               ramp_mode_in = 1'b0;
               state_in     = S_DIV;
            end else if (entry_steps == STEPS_RESTART) begin
               phase_in = PH_INITIAL;
            end else begin
               // ramp: rate is the 16.16 distance over the step count, truncated
               div_req.start    = 1'b1;
               div_req.dividend = ramp_num_mag;
               div_req.divisor  = steps_mag;
               div_req.negate   = ramp_num[31] ^ entry_steps[15];
               ramp_mode_in     = 1'b1;
               state_in         = S_DIV;
            end
         end

         S_DIV: begin
            if (!ramp_mode_ff) begin
               // jump: the entry is still on the read port, quotient is registered
               position_in = jump_rem[POS_W-1:0];
               state_in    = S_APPLY;
            end else if (div_rsp.done) begin
               ramp_rate_in = div_rsp.quotient;
               phase_in     = PH_FADE;
               position_in  = pos_inc;
               state_in     = S_STEP;
            end
         end

         S_STEP: begin
            fine_level_in = fine_sum;
            level_in      = fine_sum[31:16];
            steps_left_in = steps_dec;
            // ramp ends when the count reaches zero or below
            if (steps_dec[15] || (steps_dec == '0)) begin
               phase_in = PH_LOOP;
            end
            state_in = S_APPLY;
         end

         S_APPLY: begin
            // waiting requests land at the end of a tick, release wins
            if (pending_ff[PEND_DECAY]) begin
               phase_in               = PH_DECAY;
               pending_in[PEND_DECAY] = 1'b0;
            end
            if (pending_ff[PEND_RELEASE]) begin
               phase_in                 = PH_RELEASE;
               pending_in[PEND_DECAY]   = 1'b0;
               pending_in[PEND_RELEASE] = 1'b0;
            end
            state_in = S_DONE;
         end

         S_DONE: begin
            // wait for the output register to be free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in       = 1'b1;
               rsp_data_in.volume = $signed(level_ff);
               rsp_data_in.phase  = phase_ff;
               rsp_data_in.active = phase_ff != PH_OFF;
               state_in           = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         initial_level_ff <= '0;
         sustain_level_ff <= '0;
         fade_out_rate_ff <= '0;
         level_ff         <= '0;
         fine_level_ff    <= '0;
         ramp_rate_ff     <= '0;
         steps_left_ff    <= '0;
         position_ff      <= '0;
         phase_ff         <= PH_OFF;
         pending_ff       <= '0;
         ramp_mode_ff     <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         initial_level_ff <= initial_level_in;
         sustain_level_ff <= sustain_level_in;
         fade_out_rate_ff <= fade_out_rate_in;
         level_ff         <= level_in;
         fine_level_ff    <= fine_level_in;
         ramp_rate_ff     <= ramp_rate_in;
         steps_left_ff    <= steps_left_in;
         position_ff      <= position_in;
         phase_ff         <= phase_in;
         pending_ff       <= pending_in;
         ramp_mode_ff     <= ramp_mode_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      jump_quo_ff <= jump_quo_in;
   end

   // program store: one write port, one registered read port at the position
   always_ff @(posedge clock) begin
      if (mem_we) begin
         program_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= program_mem[position_ff];
   end

   // divider only answers while the sequencer waits for it
   `ADSR_ASSERT_NOW(a_div_done_in_div, div_rsp.done, state_ff == S_DIV, "divider done outside wait")
   // position always addresses a real entry
   `ADSR_ASSERT_NOW(a_pos_range, 1'b1,
      {1'b0, position_ff} < (POS_W+1)'(PROGRAM_DEPTH), "position out of range")
   // a free output register takes the result of the finished item
   `ADSR_ASSERT_NEXT(a_done_loads_rsp, state_ff == S_DONE && !rsp_valid_ff,
      rsp_chan.valid && state_ff == S_IDLE, "result not registered")
   // active flag agrees with the phase of a waiting result
   `ADSR_ASSERT_NOW(a_active_phase, rsp_chan.valid,
      rsp_chan.data.active == (rsp_chan.data.phase != PH_OFF), "active flag mismatch")

endmodule

/* rtl/core/adsr_div.sv */
// radix-2 restoring divider, one quotient bit per cycle
module adsr_div import adsr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   localparam int CNT_W = $clog2(DIV_STEPS);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [31:0]      quo_ff, quo_in;
   logic [15:0]      rem_ff, rem_in;
   logic [15:0]      divisor_ff, divisor_in;
   logic             neg_ff, neg_in;

   logic [16:0] trial;
   logic [16:0] trial_sub;
   logic        fits;

   always_comb begin
      trial     = {rem_ff, quo_ff[31]};
      trial_sub = trial - {1'b0, divisor_ff};
      fits      = trial >= {1'b0, divisor_ff};

      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      neg_in     = neg_ff;

      if (div_req.start) begin
         busy_in    = 1'b1;
         cnt_in     = '0;
         quo_in     = div_req.dividend;
         rem_in     = '0;
         divisor_in = div_req.divisor;
         neg_in     = div_req.negate;
      end else if (busy_ff) begin
         rem_in = fits ? trial_sub[15:0] : trial[15:0];
         quo_in = {quo_ff[30:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      neg_ff     <= neg_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = neg_ff ? (32'd0 - quo_ff) : quo_ff;

endmodule
